### src/polyphonic_key_voice_allocator_defines.svh
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_KEY_VOICE_ALLOCATOR_DEFINES_SVH
`define POLYPHONIC_KEY_VOICE_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PKVA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PKVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pkva_pkg.sv
// ----------------------------------------------------------------------------
// Voice allocator package
// Widths, defaults, event codes, state encoding and frequency tables.
// ----------------------------------------------------------------------------
package pkva_pkg;

  localparam int NUM_VOICES_DEF      = 9;
  localparam int NUM_KEYS_DEF        = 12;
  localparam int NUM_OCTAVES_DEF     = 8;
  localparam int NUM_INSTRUMENTS_DEF = 128;

  localparam int KeyBits   = 12;
  localparam int KeyIdxW   = 4;
  localparam int VoiceW    = 4;
  localparam int FnumLoW   = 8;
  localparam int BlockW    = 5;
  localparam int InstrW    = 7;
  localparam int OctaveW   = 3;
  localparam int EventW    = 2;

  localparam logic [OctaveW-1:0] OctaveReset = 3'd3;

  typedef enum logic [EventW-1:0] {
    EV_KEY_ON     = 2'd0,
    EV_RELEASE    = 2'd1,
    EV_NO_VOICE   = 2'd2,
    EV_CHIP_RESET = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_CLEAR = 3'b100
  } state_e;

  typedef struct packed {
    logic              alloc;
    logic [VoiceW-1:0] alloc_voice;
    logic              rel;
    logic [VoiceW-1:0] rel_voice;
    logic              clear;
  } pool_cmd_t;

  typedef struct packed {
    logic              found;
    logic [VoiceW-1:0] voice;
  } pool_stat_t;

  function automatic logic [FnumLoW-1:0] fnum_lo(input logic [KeyIdxW-1:0] key);
    logic [FnumLoW-1:0] r;
    case (key)
      4'd0:    r = 8'h6b;
      4'd1:    r = 8'h81;
      4'd2:    r = 8'h98;
      4'd3:    r = 8'hb0;
      4'd4:    r = 8'hca;
      4'd5:    r = 8'he5;
      4'd6:    r = 8'h02;
      4'd7:    r = 8'h20;
      4'd8:    r = 8'h41;
      4'd9:    r = 8'h63;
      4'd10:   r = 8'h87;
      4'd11:   r = 8'hae;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] fnum_hi(input logic [KeyIdxW-1:0] key);
    logic [1:0] r;
    case (key) inside
      [4'd0:4'd5]:  r = 2'd1;
      [4'd6:4'd11]: r = 2'd2;
      default:      r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

### src/pkva_if.sv
// ----------------------------------------------------------------------------
// Voice allocator channels
// Scan tick input channel and event output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pkva_in_if
  import pkva_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [KeyBits-1:0]   keys_down;
  logic                 clear_all;
  logic                 octave_up;
  logic                 octave_down;
  logic                 instrument_up;
  logic                 instrument_down;

  modport source (
    output valid, keys_down, clear_all, octave_up, octave_down,
           instrument_up, instrument_down,
    input  ready
  );
  modport sink (
    input  valid, keys_down, clear_all, octave_up, octave_down,
           instrument_up, instrument_down,
    output ready
  );
endinterface

interface pkva_out_if
  import pkva_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [EventW-1:0]   event_res;
  logic [KeyIdxW-1:0]  key_index;
  logic [VoiceW-1:0]   voice;
  logic [FnumLoW-1:0]  fnum_low;
  logic [BlockW-1:0]   block_fnum;
  logic [InstrW-1:0]   instrument;
  logic                last;

  modport source (
    output valid, event_res, key_index, voice, fnum_low, block_fnum,
           instrument, last,
    input  ready
  );
  modport sink (
    input  valid, event_res, key_index, voice, fnum_low, block_fnum,
           instrument, last,
    output ready
  );
endinterface

### src/pkva_voice_pool.sv
// ----------------------------------------------------------------------------
// Voice pool
// Busy flags of the voices and the lowest-free-voice search.
// ----------------------------------------------------------------------------
module pkva_voice_pool
  import pkva_pkg::*;
#(
  parameter int NumVoices = NUM_VOICES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pool_cmd_t  cmd_i,
  output pool_stat_t stat_o
);

  logic [NumVoices-1:0] busy_q, busy_d;

  always_comb begin
    stat_o.found = 1'b0;
    stat_o.voice = '0;
    for (int i = NumVoices - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        stat_o.found = 1'b1;
        stat_o.voice = VoiceW'(i);
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    for (int i = 0; i < NumVoices; i++) begin
      if (cmd_i.clear) begin
        busy_d[i] = 1'b0;
      end else if (cmd_i.alloc && cmd_i.alloc_voice == VoiceW'(i)) begin
        busy_d[i] = 1'b1;
      end else if (cmd_i.rel && cmd_i.rel_voice == VoiceW'(i)) begin
        busy_d[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      busy_q <= busy_d;
    end
  end

endmodule

### src/polyphonic_key_voice_allocator.sv
// ----------------------------------------------------------------------------
// Polyphonic key voice allocator
// Scans the keys one per cycle unless a held output beat stalls, assigns voices and emits key events.
// ----------------------------------------------------------------------------
// Channel | Dir | Beat
// in_i    | in  | one scan tick: key mask, clear, octave and instrument steps
// out_o   | out | one event: code, key, voice, frequency, instrument, last
//
// A tick is accepted while idle, then the scan visits each key (NumKeys) in turn,
// then the chip reset event follows when clear_all is set. No new tick is taken
// until that is done; the key scan sequencer and the single voice search unit
// set this order.
// A held output beat stalls the scan only on keys that produce an event and on
// the chip reset.
// Reset frees all voices, marks all keys silent, octave 3, instrument 0.
module polyphonic_key_voice_allocator
  import pkva_pkg::*;
#(
  parameter int NumVoices      = NUM_VOICES_DEF,
  parameter int NumKeys        = NUM_KEYS_DEF,
  parameter int NumOctaves     = NUM_OCTAVES_DEF,
  parameter int NumInstruments = NUM_INSTRUMENTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pkva_in_if.sink       in_i,
  pkva_out_if.source    out_o
);

  localparam int InstCntW = (NumInstruments > 1) ? $clog2(NumInstruments) : 1;

  state_e              state_q, state_d;
  logic [KeyIdxW-1:0]  key_q, key_d;
  logic [KeyBits-1:0]  keys_q;
  logic                clr_q, oct_up_q, oct_dn_q, ins_up_q, ins_dn_q;
  logic [NumKeys-1:0]  playing_q, playing_d;
  logic [VoiceW-1:0]   kv_q [NumKeys];
  logic [VoiceW-1:0]   kv_d [NumKeys];
  logic [OctaveW-1:0]  octave_q, octave_d;
  logic [InstCntW-1:0] instr_q, instr_d;

  logic                out_valid_q;
  event_e              ev_q, ev_d;
  logic [KeyIdxW-1:0]  okey_q, okey_d;
  logic [VoiceW-1:0]   ovoice_q, ovoice_d;
  logic [FnumLoW-1:0]  ofnum_q, ofnum_d;
  logic [BlockW-1:0]   oblock_q, oblock_d;
  logic [InstrW-1:0]   oinstr_q, oinstr_d;
  logic                olast_q, olast_d;

  logic [NumKeys-1:0]  down_vec, pend;
  logic                cur_down, cur_play, later_pend, need_evt;
  logic [VoiceW-1:0]   cur_kv;
  logic                can_push, push, tick_done, accept;
  logic                key_last;
  pool_cmd_t           pool_cmd;
  pool_stat_t          pool_stat;

  pkva_voice_pool #(
    .NumVoices(NumVoices)
  ) u_pool (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (pool_cmd),
    .stat_o(pool_stat)
  );

  for (genvar i = 0; i < NumKeys; i++) begin : g_down
    if (i < KeyBits) begin : g_in
      assign down_vec[i] = keys_q[i];
    end else begin : g_none
      assign down_vec[i] = 1'b0;
    end
  end

  assign pend     = down_vec ^ playing_q;
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept   = in_i.valid && in_i.ready;
  assign can_push = !out_valid_q || out_o.ready;
  assign key_last = (key_q == KeyIdxW'(NumKeys - 1));

  always_comb begin
    cur_down   = 1'b0;
    cur_play   = 1'b0;
    cur_kv     = '0;
    later_pend = 1'b0;
    for (int i = 0; i < NumKeys; i++) begin
      if (key_q == KeyIdxW'(i)) begin
        cur_down = down_vec[i];
        cur_play = playing_q[i];
        cur_kv   = kv_q[i];
      end
      if (KeyIdxW'(i) > key_q && pend[i]) begin
        later_pend = 1'b1;
      end
    end
  end

  assign need_evt = cur_down ^ cur_play;

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    playing_d = playing_q;
    kv_d      = kv_q;
    push      = 1'b0;
    tick_done = 1'b0;
    pool_cmd  = '0;
    ev_d      = EV_KEY_ON;
    okey_d    = '0;
    ovoice_d  = '0;
    ofnum_d   = '0;
    oblock_d  = '0;
    oinstr_d  = '0;
    olast_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          key_d   = '0;
        end
      end
      ST_SCAN: begin
        if (!need_evt || can_push) begin
          if (need_evt) begin
            push    = 1'b1;
            okey_d  = key_q;
            olast_d = !later_pend && !clr_q;
            if (cur_down) begin
              if (pool_stat.found) begin
                ev_d                 = EV_KEY_ON;
                ovoice_d             = pool_stat.voice;
                ofnum_d              = fnum_lo(key_q);
                oblock_d             = {octave_q, fnum_hi(key_q)};
                oinstr_d             = InstrW'(instr_q);
                pool_cmd.alloc       = 1'b1;
                pool_cmd.alloc_voice = pool_stat.voice;
                for (int i = 0; i < NumKeys; i++) begin
                  if (key_q == KeyIdxW'(i)) begin
                    playing_d[i] = 1'b1;
                    kv_d[i]      = pool_stat.voice;
                  end
                end
              end else begin
                ev_d = EV_NO_VOICE;
              end
            end else begin
              ev_d               = EV_RELEASE;
              ovoice_d           = cur_kv;
              pool_cmd.rel       = 1'b1;
              pool_cmd.rel_voice = cur_kv;
              for (int i = 0; i < NumKeys; i++) begin
                if (key_q == KeyIdxW'(i)) begin
                  playing_d[i] = 1'b0;
                end
              end
            end
          end
          if (key_last) begin
            if (clr_q) begin
              state_d = ST_CLEAR;
            end else begin
              state_d   = ST_IDLE;
              tick_done = 1'b1;
            end
          end else begin
            key_d = key_q + KeyIdxW'(1);
          end
        end
      end
      ST_CLEAR: begin
        if (can_push) begin
          push           = 1'b1;
          ev_d           = EV_CHIP_RESET;
          olast_d        = 1'b1;
          pool_cmd.clear = 1'b1;
          tick_done      = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    octave_d = octave_q;
    instr_d  = instr_q;
    if (tick_done) begin
      if (oct_up_q && ({1'b0, octave_d} + 4'd1) < 4'(NumOctaves)) begin
        octave_d = octave_d + OctaveW'(1);
      end
      if (oct_dn_q && octave_d != '0) begin
        octave_d = octave_d - OctaveW'(1);
      end
      if (ins_up_q &&
          ({1'b0, instr_d} + (InstCntW+1)'(1)) < (InstCntW+1)'(NumInstruments)) begin
        instr_d = instr_d + InstCntW'(1);
      end
      if (ins_dn_q && instr_d != '0) begin
        instr_d = instr_d - InstCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_q       <= '0;
      playing_q   <= '0;
      for (int i = 0; i < NumKeys; i++) begin
        kv_q[i] <= '0;
      end
      octave_q    <= OctaveReset;
      instr_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      key_q     <= key_d;
      playing_q <= playing_d;
      kv_q      <= kv_d;
      octave_q  <= octave_d;
      instr_q   <= instr_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      keys_q   <= in_i.keys_down;
      clr_q    <= in_i.clear_all;
      oct_up_q <= in_i.octave_up;
      oct_dn_q <= in_i.octave_down;
      ins_up_q <= in_i.instrument_up;
      ins_dn_q <= in_i.instrument_down;
    end
    if (push) begin
      ev_q     <= ev_d;
      okey_q   <= okey_d;
      ovoice_q <= ovoice_d;
      ofnum_q  <= ofnum_d;
      oblock_q <= oblock_d;
      oinstr_q <= oinstr_d;
      olast_q  <= olast_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.event_res  = ev_q;
  assign out_o.key_index  = okey_q;
  assign out_o.voice      = ovoice_q;
  assign out_o.fnum_low   = ofnum_q;
  assign out_o.block_fnum = oblock_q;
  assign out_o.instrument = oinstr_q;
  assign out_o.last       = olast_q;

endmodule

### src/pkva_checker.sv
// ----------------------------------------------------------------------------
// Voice allocator port checker
// Watches the channels of the top level and checks event and handshake rules.
// ----------------------------------------------------------------------------
`include "polyphonic_key_voice_allocator_defines.svh"

module pkva_checker
  import pkva_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [EventW-1:0]  event_res_i,
  input logic [KeyIdxW-1:0] key_index_i,
  input logic [VoiceW-1:0]  voice_i,
  input logic [FnumLoW-1:0] fnum_low_i,
  input logic [BlockW-1:0]  block_fnum_i,
  input logic [InstrW-1:0]  instrument_i,
  input logic               last_i
);

  `PKVA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i, "input ready right after a tick was accepted")
  `PKVA_ASSERT_SAME(a_reset_is_last, out_valid_i && event_res_i == EV_CHIP_RESET, last_i && key_index_i == '0 && voice_i == '0, "chip reset beat malformed")
  `PKVA_ASSERT_SAME(a_unused_zero, out_valid_i && event_res_i != EV_KEY_ON, fnum_low_i == '0 && block_fnum_i == '0 && instrument_i == '0, "non key-on beat carries frequency data")
  `PKVA_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(event_res_i) && $stable(voice_i) && $stable(last_i), "stalled output beat changed")

endmodule

bind polyphonic_key_voice_allocator pkva_checker u_pkva_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .event_res_i (out_o.event_res),
  .key_index_i (out_o.key_index),
  .voice_i     (out_o.voice),
  .fnum_low_i  (out_o.fnum_low),
  .block_fnum_i(out_o.block_fnum),
  .instrument_i(out_o.instrument),
  .last_i      (out_o.last)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Feeds scan ticks to the allocator through its valid/ready channels and
// checks every event beat against an in-bench allocator model. A short table
// of directed ticks comes first, then a forced output hold-off, then three
// random phases with different idling on each side.
// ----------------------------------------------------------------------------
module tb_top
  import pkva_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int OCT_TOP      = NUM_OCTAVES_DEF - 1;
  localparam int INSTR_TOP    = NUM_INSTRUMENTS_DEF - 1;
  localparam int PH_SRC  [3]  = '{10, 48, 0};
  localparam int PH_SINK [3]  = '{48, 10, 0};
  localparam int PH_LEN  [3]  = '{140, 100, 32};
  localparam int PH_IUP  [3]  = '{97, 2, 50};
  localparam int PH_IDN  [3]  = '{2, 97, 50};
  localparam logic [FnumLoW-1:0] FNUM_LO [NUM_KEYS_DEF] = '{
    8'h6b, 8'h81, 8'h98, 8'hb0, 8'hca, 8'he5,
    8'h02, 8'h20, 8'h41, 8'h63, 8'h87, 8'hae
  };

  typedef struct packed {
    logic [KeyBits-1:0] keys;
    logic               clr;
    logic               oct_up;
    logic               oct_dn;
    logic               ins_up;
    logic               ins_dn;
  } tick_t;

  typedef struct packed {
    event_e              ev;
    logic [KeyIdxW-1:0]  key;
    logic [VoiceW-1:0]   voice;
    logic [FnumLoW-1:0]  fnum;
    logic [BlockW-1:0]   blk;
    logic [InstrW-1:0]   instr;
    logic                last;
  } event_t;

  typedef struct {
    tick_t  t;
    bit     typed;
    event_t want;
  } row_t;

  typedef struct {
    bit     typed;
    event_t want;
  } offer_t;

  logic clk_i;
  logic rst_ni;

  pkva_in_if  in_if ();
  pkva_out_if out_if ();

  polyphonic_key_voice_allocator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bit                vbusy    [NUM_VOICES_DEF];
  bit                kplaying [NUM_KEYS_DEF];
  logic [VoiceW-1:0] kvoice   [NUM_KEYS_DEF];
  logic [OctaveW-1:0] oct_st;
  logic [InstrW-1:0]  instr_st;

  event_t scan_events[$];
  event_t pending_events[$];
  offer_t offered_ticks[$];
  row_t   dir_rows[$];

  int err_cnt = 0;
  int ticks_seen = 0;
  int beat_no = 0;
  int ev_seen [4] = '{0, 0, 0, 0};
  int instr_peak = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_req = 0;
  int cycles = 0;
  logic [KeyBits-1:0] last_keys = '0;

  function automatic event_t mk_event(input event_e ev, input logic [KeyIdxW-1:0] key,
                                      input logic [VoiceW-1:0] voice,
                                      input logic [FnumLoW-1:0] fnum,
                                      input logic [BlockW-1:0] blk,
                                      input logic [InstrW-1:0] instr, input logic last);
    event_t e;
    e.ev    = ev;
    e.key   = key;
    e.voice = voice;
    e.fnum  = fnum;
    e.blk   = blk;
    e.instr = instr;
    e.last  = last;
    return e;
  endfunction

  function automatic void predict_scan(input tick_t t);
    int free_v;
    scan_events.delete();
    for (int k = 0; k < NUM_KEYS_DEF; k++) begin
      if (t.keys[k] && !kplaying[k]) begin
        free_v = -1;
        for (int v = NUM_VOICES_DEF - 1; v >= 0; v--) begin
          if (!vbusy[v]) free_v = v;
        end
        if (free_v >= 0) begin
          vbusy[free_v] = 1'b1;
          kplaying[k]   = 1'b1;
          kvoice[k]     = free_v[VoiceW-1:0];
          scan_events.push_back(mk_event(EV_KEY_ON, k[KeyIdxW-1:0], free_v[VoiceW-1:0],
                                         FNUM_LO[k], {oct_st, (k < 6) ? 2'd1 : 2'd2},
                                         instr_st, 1'b0));
        end else begin
          scan_events.push_back(mk_event(EV_NO_VOICE, k[KeyIdxW-1:0], '0, '0, '0, '0, 1'b0));
        end
      end
      if (!t.keys[k] && kplaying[k]) begin
        kplaying[k]       = 1'b0;
        vbusy[kvoice[k]]  = 1'b0;
        scan_events.push_back(mk_event(EV_RELEASE, k[KeyIdxW-1:0], kvoice[k],
                                       '0, '0, '0, 1'b0));
      end
    end
    if (t.clr) begin
      foreach (vbusy[v]) vbusy[v] = 1'b0;
      scan_events.push_back(mk_event(EV_CHIP_RESET, '0, '0, '0, '0, '0, 1'b0));
    end
    if (t.oct_up && oct_st != OCT_TOP) oct_st++;
    if (t.oct_dn && oct_st != 0) oct_st--;
    if (t.ins_up && instr_st != INSTR_TOP) instr_st++;
    if (t.ins_dn && instr_st != 0) instr_st--;
    if (instr_st > instr_peak) instr_peak = instr_st;
    if (scan_events.size() > 0) scan_events[scan_events.size() - 1].last = 1'b1;
  endfunction

  task automatic report_err(input string msg);
    if (err_cnt < 40) $display("MISMATCH at %0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic add_row(input logic [KeyBits-1:0] keys, input logic clr, oup, odn, iup,
                         idn, input bit typed, input event_t want);
    row_t r;
    r.t     = {keys, clr, oup, odn, iup, idn};
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  function automatic tick_t next_tick(input int iup_pct, input int idn_pct);
    tick_t t;
    int    sel;
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      t.keys = '0;
    end else if (sel < 14) begin
      t.keys = '1;
    end else if (sel < 26) begin
      t.keys = KeyBits'($urandom_range(0, 4095));
    end else begin
      t.keys = last_keys ^ (12'd1 << $urandom_range(0, 11))
               ^ (($urandom_range(0, 2) == 0) ? (12'd1 << $urandom_range(0, 11)) : 12'd0);
    end
    last_keys = t.keys;
    t.clr    = ($urandom_range(0, 99) < 6);
    t.oct_up = ($urandom_range(0, 99) < 20);
    t.oct_dn = ($urandom_range(0, 99) < 15);
    t.ins_up = ($urandom_range(0, 99) < iup_pct);
    t.ins_dn = ($urandom_range(0, 99) < idn_pct);
    return t;
  endfunction

  task automatic send(input tick_t t, input bit typed, input event_t want);
    offer_t o;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    in_if.valid           <= 1'b1;
    in_if.keys_down       <= t.keys;
    in_if.clear_all       <= t.clr;
    in_if.octave_up       <= t.oct_up;
    in_if.octave_down     <= t.oct_dn;
    in_if.instrument_up   <= t.ins_up;
    in_if.instrument_down <= t.ins_dn;
    o.typed = typed;
    o.want  = want;
    offered_ticks.push_back(o);
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_events.size() != 0 || offered_ticks.size() != 0);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d events outstanding.", cycles,
                 pending_events.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    tick_t  tk;
    event_t got;
    event_t want;
    offer_t o;
    if (!rst_ni) begin
      foreach (vbusy[v]) vbusy[v] = 1'b0;
      foreach (kplaying[k]) begin
        kplaying[k] = 1'b0;
        kvoice[k]   = '0;
      end
      oct_st   = OctaveReset;
      instr_st = '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        tk = {in_if.keys_down, in_if.clear_all, in_if.octave_up, in_if.octave_down,
              in_if.instrument_up, in_if.instrument_down};
        predict_scan(tk);
        ticks_seen++;
        if (offered_ticks.size() == 0) begin
          report_err("scan tick accepted that was never offered");
        end else begin
          o = offered_ticks.pop_front();
          if (o.typed) begin
            pending_events.push_back(o.want);
          end else begin
            foreach (scan_events[i]) pending_events.push_back(scan_events[i]);
          end
        end
      end
      if (out_if.valid && out_if.ready) begin
        got = mk_event(event_e'(out_if.event_res), out_if.key_index, out_if.voice,
                       out_if.fnum_low, out_if.block_fnum, out_if.instrument, out_if.last);
        if (pending_events.size() == 0) begin
          report_err($sformatf("beat %0d: event %0d with none expected", beat_no, got.ev));
        end else begin
          want = pending_events.pop_front();
          ev_seen[want.ev]++;
          if (got.ev !== want.ev)
            report_err($sformatf("beat %0d: event %0d, expected %0d", beat_no, got.ev,
                                 want.ev));
          if (got.key !== want.key)
            report_err($sformatf("beat %0d: key %0d, expected %0d", beat_no, got.key,
                                 want.key));
          if (got.voice !== want.voice)
            report_err($sformatf("beat %0d: voice %0d, expected %0d", beat_no, got.voice,
                                 want.voice));
          if (got.fnum !== want.fnum)
            report_err($sformatf("beat %0d: fnum low %h, expected %h", beat_no, got.fnum,
                                 want.fnum));
          if (got.blk !== want.blk)
            report_err($sformatf("beat %0d: block %0d, expected %0d", beat_no, got.blk,
                                 want.blk));
          if (got.instr !== want.instr)
            report_err($sformatf("beat %0d: instrument %0d, expected %0d", beat_no,
                                 got.instr, want.instr));
          if (got.last !== want.last)
            report_err($sformatf("beat %0d: last %b, expected %b", beat_no, got.last,
                                 want.last));
        end
        beat_no++;
      end
    end
  end

  initial begin
    tick_t t;
    rst_ni                <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.keys_down       <= '0;
    in_if.clear_all       <= 1'b0;
    in_if.octave_up       <= 1'b0;
    in_if.octave_down     <= 1'b0;
    in_if.instrument_up   <= 1'b0;
    in_if.instrument_down <= 1'b0;

    add_row(12'h000, 0, 0, 0, 0, 0, 0, '0);
    add_row(12'h001, 0, 0, 0, 0, 0, 1,
            mk_event(EV_KEY_ON, 4'd0, 4'd0, 8'h6b, 5'd13, 7'd0, 1'b1));
    add_row(12'h000, 0, 0, 0, 0, 0, 1,
            mk_event(EV_RELEASE, 4'd0, 4'd0, 8'h00, 5'd0, 7'd0, 1'b1));
    add_row(12'h000, 1, 0, 0, 0, 0, 1,
            mk_event(EV_CHIP_RESET, 4'd0, 4'd0, 8'h00, 5'd0, 7'd0, 1'b1));
    add_row(12'hfff, 0, 0, 0, 0, 0, 0, '0);
    add_row(12'hfff, 0, 0, 0, 0, 0, 0, '0);
    add_row(12'h0ff, 1, 0, 0, 0, 0, 0, '0);
    add_row(12'hfff, 0, 0, 0, 0, 0, 0, '0);
    add_row(12'h000, 0, 0, 0, 0, 0, 0, '0);
    repeat (4) add_row(12'h000, 0, 1, 0, 0, 0, 0, '0);
    add_row(12'h800, 0, 1, 0, 0, 0, 1,
            mk_event(EV_KEY_ON, 4'd11, 4'd0, 8'hae, 5'd30, 7'd0, 1'b1));
    add_row(12'h000, 0, 0, 1, 1, 0, 1,
            mk_event(EV_RELEASE, 4'd11, 4'd0, 8'h00, 5'd0, 7'd0, 1'b1));
    repeat (6) add_row(12'h000, 0, 0, 1, 0, 1, 0, '0);
    add_row(12'h001, 0, 0, 1, 0, 0, 1,
            mk_event(EV_KEY_ON, 4'd0, 4'd0, 8'h6b, 5'd1, 7'd0, 1'b1));
    add_row(12'h003, 0, 1, 1, 1, 1, 0, '0);
    add_row(12'h000, 1, 0, 0, 0, 0, 0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct  = PH_SRC[0];
    sink_idle_pct = PH_SINK[0];
    foreach (dir_rows[i]) send(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].want);
    wait_idle();

    src_idle_pct = 0;
    hold_req     = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) begin
      t      = next_tick(30, 30);
      t.keys = i[0] ? 12'h000 : 12'hfff;
      send(t, 1'b0, '0);
    end
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = PH_SRC[ph];
      sink_idle_pct = PH_SINK[ph];
      for (int i = 0; i < PH_LEN[ph]; i++) send(next_tick(PH_IUP[ph], PH_IDN[ph]), 1'b0, '0);
      wait_idle();
    end

    $display("Covered %0d ticks, %0d events: %0d key-on, %0d release, %0d no voice, %0d reset.",
             ticks_seen, beat_no, ev_seen[EV_KEY_ON], ev_seen[EV_RELEASE],
             ev_seen[EV_NO_VOICE], ev_seen[EV_CHIP_RESET]);
    $display("Instrument peaked at %0d; one %0d-cycle output hold-off backed up the input.",
             instr_peak, HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/pkva_pkg.sv
src/pkva_if.sv
src/pkva_voice_pool.sv
src/polyphonic_key_voice_allocator.sv
src/pkva_checker.sv
tb/tb_top.sv
